>>> rtl/pdlr_pkg.sv
// Package with the shared constants and the controller/datapath command and status types.
package pdlr_pkg;

  // Widths of the configuration registers and fields.
  localparam int FMT_W       = 2;
  localparam int CHCNT_W     = 4;
  localparam int STEP_REG_W  = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int WORD_W      = 32;
  localparam int PCM_W       = 16;
  localparam int MONO_W      = 32;
  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;

  // Sample encodings.
  localparam logic [FMT_W-1:0] FMT_PCM16 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_PCM24 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_PCM32 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_F32   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic accum;
    logic div_step;
    logic mono;
    logic finish;
    logic mul;
    logic ycalc;
    logic emit;
  } pdlr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close;
    logic div_done;
    logic have_prev;
    logic more;
    logic slot_free;
  } pdlr_stat_t;

endpackage

>>> rtl/pdlr_if.sv
// Stream interfaces for the sample input channel and the resampled output channel.
interface pdlr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_word;
  logic        frame_end;
  logic        silent;

  modport source (output valid, output sample_word, output frame_end, output silent,
                  input ready);
  modport sink (input valid, input sample_word, input frame_end, input silent,
                output ready);
endinterface

interface pdlr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_out;
  logic               last_of_run;

  modport source (output valid, output pcm_out, output last_of_run, input ready);
  modport sink (input valid, input pcm_out, input last_of_run, output ready);
endinterface

>>> rtl/pcm_downmix_linear_resampler.sv
// Top level of the mono downmix and linear-interpolation sample rate converter.
// One channel sample is taken per word; a word that does not close a frame is accepted,
// then decoded and accumulated. A word that closes a frame also runs the downmix divider,
// which produces one quotient bit per cycle, then the mono sample step, and for each output
// word the steps check, multiply, sum and emit, the emit waiting while the output stalls,
// plus a closing check. No new word is accepted until this sequence returns to idle.
module pcm_downmix_linear_resampler
  import pdlr_pkg::*;
#(
  parameter int MAX_CHANNELS    = 8,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pdlr_in_if.sink               in_ch,
  pdlr_out_if.source            out_ch
);

  pdlr_cmd_t  cmd;
  pdlr_stat_t stat;

  pdlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdlr_dp #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample_word  (in_ch.sample_word),
    .in_frame_end    (in_ch.frame_end),
    .in_silent       (in_ch.silent),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_pcm_out     (out_ch.pcm_out),
    .out_last_of_run (out_ch.last_of_run),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

>>> rtl/pdlr_dp.sv
// Datapath: configuration, sample decode, downmix divider, interpolator and output register.
module pdlr_dp
  import pdlr_pkg::*;
#(
  parameter int MAX_CHANNELS    = 8,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [WORD_W-1:0]     in_sample_word,
  input  logic                  in_frame_end,
  input  logic                  in_silent,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed [PCM_W-1:0] out_pcm_out,
  output logic                  out_last_of_run,
  input  pdlr_cmd_t             cmd,
  output pdlr_stat_t            stat
);

  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CW     = (CNT_W > CHCNT_W) ? CNT_W : CHCNT_W;
  localparam int SUM_W  = MONO_W + $clog2(MAX_CHANNELS);
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int F      = PHASE_FRAC_BITS;
  localparam int PH_W   = PHASE_FRAC_BITS + 4;
  localparam int EW     = (PH_W > STEP_REG_W) ? PH_W : STEP_REG_W;
  localparam int PROD_W = MONO_W + 1 + F + 1;
  localparam logic [PH_W-1:0] ONE      = PH_W'(1) << F;
  localparam logic [EW-1:0]   STEP_MIN = EW'(1) << (F - 3);
  localparam logic [EW-1:0]   STEP_MAX = EW'(12) << F;

  // Configuration registers.
  logic [FMT_W-1:0]      fmt_r;
  logic [CHCNT_W-1:0]    chcnt_r;
  logic [STEP_REG_W-1:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_PCM16;
      chcnt_r <= CHCNT_W'(1);
      step_r  <= STEP_REG_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT:   fmt_r   <= cfg_data[FMT_W-1:0];
        REG_CHANNELS: chcnt_r <= cfg_data[CHCNT_W-1:0];
        REG_STEP:     step_r  <= cfg_data[STEP_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective channel count and step after range saturation.
  logic [CW-1:0]   cnt_wide;
  logic [CNT_W-1:0] cnt_eff;
  logic [EW-1:0]   step_wide;
  logic [PH_W-1:0] step_eff;

  always_comb begin
    cnt_wide = CW'(chcnt_r);
    if (cnt_wide == '0) begin
      cnt_wide = CW'(1);
    end else if (cnt_wide > CW'(MAX_CHANNELS)) begin
      cnt_wide = CW'(MAX_CHANNELS);
    end
    cnt_eff = cnt_wide[CNT_W-1:0];
    step_wide = EW'(step_r);
    if (step_wide < STEP_MIN) begin
      step_wide = STEP_MIN;
    end else if (step_wide > STEP_MAX) begin
      step_wide = STEP_MAX;
    end
    step_eff = step_wide[PH_W-1:0];
  end

  // Input word holding register.
  logic [WORD_W-1:0] word_r;
  logic              fend_r;
  logic              sil_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_sample_word;
      fend_r <= in_frame_end;
      sil_r  <= in_silent;
    end
  end

  // Sample decode to signed Q1.31.
  logic [7:0]         f_ex;
  logic [23:0]        f_sig;
  logic [31:0]        f_mag;
  logic signed [31:0] f_val;
  logic signed [31:0] dec;

  always_comb begin
    f_ex  = word_r[30:23];
    f_sig = {1'b1, word_r[22:0]};
    f_mag = '0;
    if (f_ex >= 8'd119) begin
      f_mag = 32'(f_sig) << (f_ex - 8'd119);
    end else begin
      f_mag = 32'(f_sig) >> (8'd119 - f_ex);
    end
    if ((f_ex == 8'hFF && word_r[22:0] != '0) || f_ex == 8'd0) begin
      f_val = '0;
    end else if (f_ex >= 8'd127) begin
      f_val = word_r[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      f_val = word_r[31] ? -$signed(f_mag) : $signed(f_mag);
    end
    case (fmt_r)
      FMT_PCM16: dec = $signed({word_r[15:0], 16'h0000});
      FMT_PCM24: dec = $signed({word_r[23:0], 8'h00});
      FMT_PCM32: dec = $signed(word_r);
      FMT_F32:   dec = f_val;
      default:   dec = '0;
    endcase
    if (sil_r) begin
      dec = '0;
    end
  end

  // Frame accumulation.
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0]        idx_r;
  logic [CNT_W-1:0]        idx_nxt;

  assign sum_nxt    = sum_r + SUM_W'(dec);
  assign idx_nxt    = idx_r + CNT_W'(1);
  assign stat.close = fend_r || (idx_nxt >= cnt_eff);

  // Restoring divider, one quotient bit per cycle.
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic              neg_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial         = {rem_r, quo_r[SUM_W-1]};
  assign ge            = trial >= {1'b0, div_r};
  assign stat.div_done = dcnt_r == DCNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
    end else if (cmd.accum) begin
      if (stat.close) begin
        sum_r <= '0;
        idx_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum && stat.close) begin
      neg_r  <= sum_nxt[SUM_W-1];
      quo_r  <= sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
      rem_r  <= '0;
      div_r  <= cnt_eff;
      dcnt_r <= DCNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      rem_r  <= ge ? CNT_W'(trial - {1'b0, div_r}) : trial[CNT_W-1:0];
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  // Interpolator state.
  logic signed [MONO_W-1:0] cur_r;
  logic signed [MONO_W-1:0] prev_r;
  logic                     have_r;
  logic [PH_W-1:0]          phase_r;
  logic [RES_CNT_W-1:0]     n_r;
  logic signed [MONO_W-1:0] quot_s;
  logic [SUM_W-1:0]         quo_signed;

  assign quo_signed     = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;
  assign quot_s         = $signed(quo_signed[MONO_W-1:0]);
  assign stat.have_prev = have_r;
  assign stat.more      = (phase_r < ONE) && (n_r < RES_CNT_W'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      have_r  <= 1'b0;
      phase_r <= '0;
      n_r     <= '0;
    end else begin
      if (cmd.mono) begin
        n_r <= '0;
        if (!have_r) begin
          prev_r  <= quot_s;
          have_r  <= 1'b1;
          phase_r <= '0;
        end
      end
      if (cmd.finish) begin
        prev_r <= cur_r;
        if (phase_r >= ONE) begin
          phase_r <= phase_r - ONE;
        end
      end
      if (cmd.emit) begin
        phase_r <= phase_r + step_eff;
        n_r     <= n_r + RES_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mono) begin
      cur_r <= quot_s;
    end
  end

  // Interpolation: y = prev + floor((cur - prev) * phase / ONE).
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MONO_W-1:0] y_r;
  logic signed [MONO_W:0]   diff;
  logic signed [PROD_W-1:0] prod_sh;

  assign diff    = (MONO_W + 1)'(cur_r) - (MONO_W + 1)'(prev_r);
  assign prod_sh = prod_r >>> F;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(diff * $signed({1'b0, phase_r[F-1:0]}));
    end
    if (cmd.ycalc) begin
      y_r <= MONO_W'(PROD_W'(prev_r) + prod_sh);
    end
  end

  // Scale to 16 bits, round half away from zero, clamp.
  logic signed [47:0]       p;
  logic [47:0]              pmag;
  logic [16:0]              q;
  logic signed [PCM_W-1:0]  pcm;
  logic                     last;

  always_comb begin
    p    = (48'(y_r) <<< 15) - 48'(y_r);
    pmag = p[47] ? 48'(-p) : 48'(p);
    q    = 17'((pmag + 48'h4000_0000) >> 31);
    if (p[47]) begin
      pcm = (q > 17'd32768) ? 16'sh8000 : PCM_W'(-$signed(q));
    end else begin
      pcm = (q > 17'd32767) ? 16'sh7FFF : PCM_W'(q);
    end
    last = ((phase_r + step_eff) >= ONE) || (n_r == RES_CNT_W'(MAX_RESULTS - 1));
  end

  // Output register.
  logic out_valid_r;

  assign stat.slot_free = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pcm_out     <= pcm;
      out_last_of_run <= last;
    end
  end

  // A word is never overwritten while it still waits at the output.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> stat.slot_free)
    else $error("emit while output word is pending");
  // An emitted word shows up at the output on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |=> out_valid_r)
    else $error("emitted word not presented");
  // The loop never runs past the result limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count overflow");

endmodule

>>> rtl/pdlr_ctrl.sv
// Controller: sequences decode, downmix division and the interpolation loop.
module pdlr_ctrl
  import pdlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pdlr_stat_t stat,
  output pdlr_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ACC   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_MONO  = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_YCALC = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = stat.close ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_MONO;
        end
      end
      S_MONO: begin
        cmd.mono  = 1'b1;
        state_nxt = stat.have_prev ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (stat.more) begin
          state_nxt = S_MUL;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_YCALC;
      end
      S_YCALC: begin
        cmd.ycalc = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // An accepted word is always decoded on the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_ACC)
    else $error("accepted word not decoded");
  // A frame that closes always goes to the divider.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && stat.close) |=> state_r == S_DIV)
    else $error("closed frame skipped division");
  // The divider ends in the mono step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && stat.div_done) |=> state_r == S_MONO)
    else $error("divider did not finish");

endmodule

>>> dv/tb_pcm_downmix_linear_resampler.sv
// Self-checking testbench of the mono downmix and linear-interpolation resampler.
module tb_pcm_downmix_linear_resampler;
  timeunit 1ns;
  timeprecision 1ps;

  import pdlr_pkg::*;

  localparam int     CH_MAX     = 8;
  localparam int     FRAC_BITS  = 16;
  localparam longint PH_ONE     = 64'sd1 << FRAC_BITS;
  localparam longint STEP_LO    = PH_ONE >> 3;
  localparam longint STEP_HI    = PH_ONE * 12;
  localparam longint Q31_MAX    = 64'sd2147483647;
  localparam longint Q31_MIN    = -64'sd2147483648;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     SETTLE_CYCLES = 120;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic                    last;
  } pcm_word_t;

  // One row of the directed table: either a register write or an input word.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [WORD_W-1:0]     word;
    bit                    fe;
    bit                    sil;
    bit                    chk;
    int                    pcm_typed;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pdlr_in_if  in_ch ();
  pdlr_out_if out_ch ();

  pcm_downmix_linear_resampler #(
    .MAX_CHANNELS   (CH_MAX),
    .PHASE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Predictor copy of the configuration and state.
  logic [FMT_W-1:0]      fmt_reg;
  logic [CHCNT_W-1:0]    chan_reg;
  logic [STEP_REG_W-1:0] step_reg;
  longint                frame_acc;
  int                    frame_pos;
  longint                last_mono;
  bit                    mono_valid;
  longint                interp_phase;

  pcm_word_t pending_pcm[$];
  int        fail_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_left;
  stim_row_t dir_rows[$];

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, and a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted output word with the oldest pending prediction.
  always @(posedge clk) begin
    pcm_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pcm.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10)
          $display("Unexpected output word pcm=%0d last=%0b", out_ch.pcm_out,
                   out_ch.last_of_run);
      end else begin
        e = pending_pcm[0];
        pending_pcm.delete(0);
        if (out_ch.pcm_out !== e.pcm || out_ch.last_of_run !== e.last) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("Mismatch: expected pcm=%0d last=%0b, got pcm=%0d last=%0b",
                     e.pcm, e.last, out_ch.pcm_out, out_ch.last_of_run);
        end
      end
    end
  end

  // Decode one raw word to Q1.31 in the current sample format.
  function automatic longint decode_q31(logic [WORD_W-1:0] w);
    logic [7:0] ex;
    longint     sig;
    longint     mag;
    int         sh;
    ex  = w[30:23];
    sig = {40'd0, 1'b1, w[22:0]};
    case (fmt_reg)
      FMT_PCM16: return longint'($signed(w[15:0])) * 65536;
      FMT_PCM24: return longint'($signed(w[23:0])) * 256;
      FMT_PCM32: return longint'($signed(w));
      default: begin
        if (ex == 8'hFF && w[22:0] != 0) return 0;
        if (ex == 8'h00) return 0;
        sh = int'(ex) - 119;
        if (sh >= 8) return w[31] ? Q31_MIN : Q31_MAX;
        if (sh >= 0) mag = sig << sh;
        else if (sh > -32) mag = sig >> (-sh);
        else mag = 0;
        return w[31] ? -mag : mag;
      end
    endcase
  endfunction

  // Scale a Q1.31 value to 16 bits, rounding half away from zero.
  function automatic logic signed [PCM_W-1:0] q31_to_pcm(longint q);
    longint p;
    longint mag;
    longint r;
    p   = q * 32767;
    mag = (p < 0) ? -p : p;
    r   = (mag + (64'sd1 << 30)) >>> 31;
    if (p < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[PCM_W-1:0];
  endfunction

  // Downmix and interpolate one accepted word; queues the output words it causes.
  task automatic predict_word(input logic [WORD_W-1:0] w, input bit fe, input bit sil,
                              output int n);
    longint cnt;
    longint step;
    longint cur;
    longint num;
    pcm_word_t r;
    n    = 0;
    cnt  = chan_reg;
    step = step_reg;
    if (cnt < 1) cnt = 1;
    if (cnt > CH_MAX) cnt = CH_MAX;
    if (step < STEP_LO) step = STEP_LO;
    if (step > STEP_HI) step = STEP_HI;
    frame_acc = frame_acc + (sil ? 64'sd0 : decode_q31(w));
    frame_pos = frame_pos + 1;
    if (!fe && frame_pos < cnt) return;
    cur       = frame_acc / cnt;
    frame_acc = 0;
    frame_pos = 0;
    if (!mono_valid) begin
      last_mono    = cur;
      mono_valid   = 1'b1;
      interp_phase = 0;
      return;
    end
    while (interp_phase < PH_ONE && n < MAX_RESULTS) begin
      num    = last_mono * (PH_ONE - interp_phase) + cur * interp_phase;
      r.pcm  = q31_to_pcm(num >>> FRAC_BITS);
      r.last = 1'b0;
      pending_pcm.insert(pending_pcm.size(), r);
      n = n + 1;
      interp_phase = interp_phase + step;
    end
    if (n > 0) pending_pcm[$].last = 1'b1;
    if (interp_phase >= PH_ONE) interp_phase = interp_phase - PH_ONE;
    last_mono = cur;
  endtask

  // Offer one word at the falling edge and hold it until it is taken.
  task automatic send_word(input logic [WORD_W-1:0] w, input bit fe, input bit sil,
                           output int n, output logic signed [PCM_W-1:0] first_pcm);
    int base;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.sample_word = w;
    in_ch.frame_end   = fe;
    in_ch.silent      = sil;
    do @(posedge clk); while (!in_ch.ready);
    base = pending_pcm.size();
    predict_word(w, fe, sil, n);
    first_pcm = (n > 0) ? pending_pcm[base].pcm : '0;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Wait until every prediction has arrived and the block has gone quiet.
  task automatic drain();
    while (pending_pcm.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      REG_FORMAT:   fmt_reg  = val[FMT_W-1:0];
      REG_CHANNELS: chan_reg = val[CHCNT_W-1:0];
      REG_STEP:     step_reg = val[STEP_REG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{1'b1, idx, val, '0, 1'b0, 1'b0, 1'b0, 0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_word(logic [WORD_W-1:0] w, bit fe, bit sil, bit chk,
                                   int pcm_typed);
    stim_row_t r;
    r = '{1'b0, '0, '0, w, fe, sil, chk, pcm_typed};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Random raw word, biased toward in-range values for float.
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    w = $urandom;
    if (fmt_reg == FMT_F32) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: w[30:23] = 8'($urandom_range(126, 100));
        6:                w[30:23] = 8'($urandom_range(130, 127));
        7:                w[30:23] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
        default: ;
      endcase
    end
    return w;
  endfunction

  // Random frames: mostly whole frames, some closed early, a few silent words.
  // The last word of each group always closes its frame, so no frame stays open
  // across a register write.
  task automatic random_words(input int count);
    int cnt;
    int len;
    int sent;
    int n;
    bit fe;
    bit early;
    logic signed [PCM_W-1:0] fp;
    cnt  = (chan_reg < 1) ? 1 : ((chan_reg > CH_MAX) ? CH_MAX : int'(chan_reg));
    sent = 0;
    while (sent < count) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(cnt, 1) : cnt;
      early = 1'b0;
      for (int k = 0; k < len; k++) begin
        if (k == len - 1) begin
          fe = (len < cnt) || early || ($urandom_range(1) == 1);
        end else begin
          fe    = ($urandom_range(19) == 0);
          early = early || fe;
        end
        send_word(rand_word(), fe, $urandom_range(9) == 0, n, fp);
        sent = sent + 1;
      end
    end
  endtask

  initial begin
    int n;
    logic signed [PCM_W-1:0] fp;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.sample_word = '0;
    in_ch.frame_end   = 1'b0;
    in_ch.silent      = 1'b0;
    out_ch.ready      = 1'b0;
    fail_count        = 0;
    cycle_count       = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_left         = 0;
    fmt_reg           = FMT_PCM16;
    chan_reg          = 4'd1;
    step_reg          = 20'd65536;
    frame_acc         = 0;
    frame_pos         = 0;
    last_mono         = 0;
    mono_valid        = 1'b0;
    interp_phase      = 0;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed rows, starting from the reset configuration.
    add_word(32'h0000_7FFF, 1, 0, 0, 0);
    add_word(32'h0000_8000, 1, 0, 1, 32766);
    add_word(32'hFFFF_0000, 1, 0, 1, -32767);
    add_word(32'h1234_5678, 1, 1, 1, 0);
    add_word(32'h0000_FFFF, 1, 0, 1, 0);
    add_cfg(REG_FORMAT, FMT_PCM24);
    add_word(32'h007F_FFFF, 1, 0, 0, 0);
    add_word(32'hFF80_0000, 1, 0, 0, 0);
    add_cfg(REG_FORMAT, FMT_F32);
    add_word(32'h3F80_0000, 1, 0, 0, 0);   // plus one saturates
    add_word(32'hBF80_0000, 1, 0, 0, 0);   // minus one
    add_word(32'h7FC0_0000, 1, 0, 0, 0);   // not a number
    add_word(32'h7F80_0000, 1, 0, 0, 0);   // positive infinity
    add_word(32'hFF80_0000, 1, 0, 0, 0);   // negative infinity
    add_word(32'h0000_0001, 1, 0, 0, 0);   // subnormal
    add_word(32'h3F00_0000, 1, 0, 0, 0);
    add_cfg(REG_FORMAT, FMT_PCM32);
    add_cfg(REG_CHANNELS, 20'd0);          // zero channels behaves as one
    add_word(32'h8000_0000, 1, 0, 0, 0);
    add_word(32'h7FFF_FFFF, 0, 0, 0, 0);
    add_cfg(REG_CHANNELS, 20'd15);         // clamped to the channel maximum
    add_cfg(REG_STEP, 20'd0);              // clamped to the smallest step
    add_word(32'h4000_0000, 0, 0, 0, 0);
    add_word(32'hC000_0000, 1, 0, 0, 0);   // frame closed early
    add_cfg(REG_STEP, 20'hFFFFF);          // clamped to the largest step
    add_word(32'h7FFF_FFFF, 1, 0, 0, 0);
    add_word(32'h8000_0000, 1, 0, 0, 0);
    add_word(32'h5555_AAAA, 1, 0, 0, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].fe, dir_rows[i].sil, n, fp);
        if (dir_rows[i].chk && (n == 0 || fp != dir_rows[i].pcm_typed)) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("Directed word %0d: expected pcm=%0d, predicted %0d words first=%0d",
                     i, dir_rows[i].pcm_typed, n, fp);
        end
      end
    end

    // Random phases over several settings and idling patterns.
    write_reg(REG_FORMAT, FMT_PCM16);
    write_reg(REG_CHANNELS, 20'd1);
    write_reg(REG_STEP, 20'd65536);
    send_idle_pct = 0;  recv_stall_pct = 0;
    random_words(20);

    write_reg(REG_FORMAT, FMT_PCM24);
    write_reg(REG_CHANNELS, 20'd2);
    write_reg(REG_STEP, 20'd180634);
    send_idle_pct = 68; recv_stall_pct = 0;
    random_words(22);

    write_reg(REG_FORMAT, FMT_PCM32);
    write_reg(REG_CHANNELS, 20'd8);
    write_reg(REG_STEP, 20'd8192);
    send_idle_pct = 0;  recv_stall_pct = 68;
    random_words(22);

    write_reg(REG_FORMAT, FMT_F32);
    write_reg(REG_CHANNELS, 20'd3);
    write_reg(REG_STEP, 20'd786432);
    send_idle_pct = 20; recv_stall_pct = 20;
    random_words(22);

    // Long receiver hold-off while the sender keeps offering words.
    write_reg(REG_FORMAT, FMT_PCM16);
    write_reg(REG_CHANNELS, 20'd1);
    write_reg(REG_STEP, 20'd0);
    send_idle_pct = 0;  recv_stall_pct = 0;
    hold_left = 400;
    random_words(22);

    write_reg(REG_FORMAT, FMT_F32);
    write_reg(REG_CHANNELS, 20'd15);
    write_reg(REG_STEP, 20'hFFFFF);
    send_idle_pct = 20; recv_stall_pct = 20;
    random_words(22);

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pdlr_pkg.sv
rtl/pdlr_if.sv
rtl/pdlr_dp.sv
rtl/pdlr_ctrl.sv
rtl/pcm_downmix_linear_resampler.sv
dv/tb_pcm_downmix_linear_resampler.sv
